// File: rtl/kcm_pkg.sv
package kcm_pkg;

  localparam int BUTTONS        = 3;
  localparam int SLOTS          = 2 * BUTTONS;
  localparam int KEY_CODE_LIMIT = 768;
  localparam int CODE_W         = 10;
  localparam int IN_CODE_W      = 16;
  localparam int REG_IDX_W      = 3;
  localparam int QDEPTH         = 2;

  localparam logic [CODE_W-1:0] MOUSE_LEFT_CODE   = 10'd272;
  localparam logic [CODE_W-1:0] MOUSE_RIGHT_CODE  = 10'd273;
  localparam logic [CODE_W-1:0] MOUSE_MIDDLE_CODE = 10'd274;

  // input op codes
  localparam logic [1:0] OP_KEY  = 2'd0;
  localparam logic [1:0] OP_SYNC = 2'd1;

  // output kinds
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_SYNC = 1'b1;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_BUTTON_COUNT    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_KEY       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_MODIFIER  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_KEY      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_MODIFIER = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_THIRD_KEY       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_THIRD_MODIFIER  = 3'd6;

  // register reset values
  localparam logic [1:0]        RST_BUTTON_COUNT    = 2'd3;
  localparam logic [CODE_W-1:0] RST_FIRST_KEY       = 10'd125;
  localparam logic [CODE_W-1:0] RST_FIRST_MODIFIER  = 10'd0;
  localparam logic [CODE_W-1:0] RST_SECOND_KEY      = 10'd125;
  localparam logic [CODE_W-1:0] RST_SECOND_MODIFIER = 10'd56;
  localparam logic [CODE_W-1:0] RST_THIRD_KEY       = 10'd125;
  localparam logic [CODE_W-1:0] RST_THIRD_MODIFIER  = 10'd100;

  // one report request handed from front to back end
  typedef struct packed {
    logic [BUTTONS-1:0]             chg;
    logic [BUTTONS-1:0]             val;
    logic [BUTTONS-1:0][CODE_W-1:0] mouse;
    logic [BUTTONS-1:0][CODE_W-1:0] key;
    logic [BUTTONS-1:0][CODE_W-1:0] modk;
  } report_t;

endpackage

// File: rtl/kcm_front.sv
module kcm_front
  import kcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 full,
  input  logic [1:0]           op,
  input  logic [IN_CODE_W-1:0] key_code,
  input  logic [1:0]           key_value,
  input  logic                 write_enable,
  input  logic [REG_IDX_W-1:0] write_index,
  input  logic [CODE_W-1:0]    write_data,
  output logic                 q_push,
  output report_t              q_data
);

  logic [1:0]                     button_count;
  logic [BUTTONS-1:0][CODE_W-1:0] cfg_key;
  logic [BUTTONS-1:0][CODE_W-1:0] cfg_mod;
  logic [SLOTS-1:0]               slot;
  logic [BUTTONS-1:0]             button_pressed;
  logic                           report_pending;

  logic [1:0]                     act_n;
  logic [BUTTONS-1:0][CODE_W-1:0] key_eff;
  logic [BUTTONS-1:0][CODE_W-1:0] mod_eff;
  logic [BUTTONS-1:0][CODE_W-1:0] mouse;
  logic [BUTTONS-1:0]             down;
  logic [BUTTONS-1:0]             cancel;
  logic [BUTTONS-1:0]             btn_next;
  logic [BUTTONS-1:0]             chg;
  logic [BUTTONS-1:0]             key_hit;
  logic [BUTTONS-1:0]             mod_hit;
  logic                           accept;
  logic                           code_ok;
  logic                           pressed;
  logic                           do_report;
  logic [CODE_W-1:0]              code_n;
  logic [REG_IDX_W-1:0]           slot_idx;

  assign accept    = push && !full;
  assign code_ok   = (key_code != '0) && (key_code < IN_CODE_W'(KEY_CODE_LIMIT));
  assign code_n    = key_code[CODE_W-1:0];
  assign pressed   = (key_value != 2'd0);
  assign act_n     = (button_count == 2'd0) ? 2'd1 : button_count;
  assign do_report = accept && (op == OP_SYNC) && report_pending;
  assign slot_idx  = write_index - REG_FIRST_KEY;

  // effective key/modifier per button, hits and mouse code
  always_comb begin
    for (int b = 0; b < BUTTONS; b++) begin
      key_eff[b] = (act_n > 2'(b)) ? cfg_key[b] : '0;
      mod_eff[b] = (key_eff[b] != '0) ? cfg_mod[b] : '0;
      key_hit[b] = code_ok && (key_eff[b] == code_n);
      mod_hit[b] = code_ok && (mod_eff[b] != '0) && (mod_eff[b] == code_n);
      down[b]    = (key_eff[b] != '0) && slot[2*b] &&
                   ((mod_eff[b] == '0) || slot[2*b+1]);
      if (b == 0)
        mouse[b] = MOUSE_LEFT_CODE;
      else if (b == 1 && act_n == 2'd2)
        mouse[b] = MOUSE_RIGHT_CODE;
      else if (b == 1)
        mouse[b] = MOUSE_MIDDLE_CODE;
      else
        mouse[b] = MOUSE_RIGHT_CODE;
    end
  end

  // a modifier combo held now or before hides the lowest plain button on its key
  always_comb begin
    logic found;
    cancel = '0;
    for (int j = 0; j < BUTTONS; j++) begin
      found = 1'b0;
      if ((mod_eff[j] != '0) && (down[j] || button_pressed[j])) begin
        for (int b = 0; b < BUTTONS; b++) begin
          if (!found && (key_eff[b] != '0) && (mod_eff[b] == '0) &&
              (key_eff[b] == key_eff[j])) begin
            cancel[b] = 1'b1;
            found     = 1'b1;
          end
        end
      end
    end
  end

  assign btn_next = down & ~cancel;
  assign chg      = btn_next ^ button_pressed;
  assign q_push   = do_report && (chg != '0);

  always_comb begin
    q_data.chg   = chg;
    q_data.val   = btn_next;
    q_data.mouse = mouse;
    q_data.key   = key_eff;
    q_data.modk  = mod_eff;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      button_count <= RST_BUTTON_COUNT;
      cfg_key[0]   <= RST_FIRST_KEY;
      cfg_mod[0]   <= RST_FIRST_MODIFIER;
      cfg_key[1]   <= RST_SECOND_KEY;
      cfg_mod[1]   <= RST_SECOND_MODIFIER;
      cfg_key[2]   <= RST_THIRD_KEY;
      cfg_mod[2]   <= RST_THIRD_MODIFIER;
    end else if (write_enable) begin
      unique case (write_index)
        REG_BUTTON_COUNT:    button_count <= write_data[1:0];
        REG_FIRST_KEY:       cfg_key[0]   <= write_data;
        REG_FIRST_MODIFIER:  cfg_mod[0]   <= write_data;
        REG_SECOND_KEY:      cfg_key[1]   <= write_data;
        REG_SECOND_MODIFIER: cfg_mod[1]   <= write_data;
        REG_THIRD_KEY:       cfg_key[2]   <= write_data;
        REG_THIRD_MODIFIER:  cfg_mod[2]   <= write_data;
        default: ;
      endcase
    end
  end

  // key tracking and report state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot           <= '0;
      button_pressed <= '0;
      report_pending <= 1'b0;
    end else begin
      if (accept && op == OP_KEY) begin
        for (int b = 0; b < BUTTONS; b++) begin
          if (key_hit[b]) begin
            slot[2*b]      <= pressed;
            report_pending <= 1'b1;
          end
          if (mod_hit[b]) begin
            slot[2*b+1]    <= pressed;
            report_pending <= 1'b1;
          end
        end
      end
      if (do_report) begin
        report_pending <= 1'b0;
        button_pressed <= btn_next;
      end
      // rewriting a key or modifier drops its held state
      if (write_enable && write_index >= REG_FIRST_KEY &&
          write_index <= REG_THIRD_MODIFIER)
        slot[slot_idx] <= 1'b0;
    end
  end

endmodule

// File: rtl/kcm_queue.sv
module kcm_queue
  import kcm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  report_t wdata,
  output logic    full,
  input  logic    pop,
  output logic    valid,
  output report_t rdata
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  report_t            mem [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(QDEPTH));
  assign valid = (count != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push)
      mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)
        count <= count + 1'b1;
      else if (pop && !push)
        count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && full))
    else $error("report queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("report queue underflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QDEPTH))
    else $error("report queue count out of range");

endmodule

// File: rtl/kcm_back.sv
module kcm_back
  import kcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  report_t           q_data,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic              event_kind,
  output logic [CODE_W-1:0] event_code,
  output logic              event_value,
  output logic              last_event
);

  typedef enum logic [1:0] {
    STEP_BUTTON,
    STEP_KEY,
    STEP_MOD
  } step_t;

  localparam int SEL_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  step_t              step;
  step_t              cur_step;
  logic               busy;
  logic               out_valid;
  logic [BUTTONS-1:0] rem;
  logic [BUTTONS-1:0] cur_rem;
  logic [BUTTONS-1:0] sel_bit;
  logic [SEL_W-1:0]   sel;
  logic               can_emit;

  assign cur_rem  = busy ? rem : q_data.chg;
  assign cur_step = busy ? step : STEP_BUTTON;
  assign can_emit = q_valid && (!out_valid || pop);
  assign q_pop    = can_emit && (cur_rem == '0);
  assign empty    = !out_valid;

  // lowest button still to be reported
  always_comb begin
    sel = '0;
    for (int b = BUTTONS - 1; b >= 0; b--) begin
      if (cur_rem[b])
        sel = SEL_W'(b);
    end
    sel_bit      = '0;
    sel_bit[sel] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
      step      <= STEP_BUTTON;
      rem       <= '0;
    end else begin
      if (pop && out_valid)
        out_valid <= 1'b0;
      if (can_emit) begin
        out_valid <= 1'b1;
        if (cur_rem == '0) begin
          // run closes with the sync copy
          event_kind  <= KIND_SYNC;
          event_code  <= '0;
          event_value <= 1'b0;
          last_event  <= 1'b1;
          busy        <= 1'b0;
          step        <= STEP_BUTTON;
        end else begin
          busy        <= 1'b1;
          event_kind  <= KIND_KEY;
          last_event  <= 1'b0;
          unique case (cur_step)
            STEP_BUTTON: begin
              event_code  <= q_data.mouse[sel];
              event_value <= q_data.val[sel];
              if (q_data.val[sel]) begin
                step <= STEP_KEY;
                rem  <= cur_rem;
              end else begin
                step <= STEP_BUTTON;
                rem  <= cur_rem & ~sel_bit;
              end
            end
            STEP_KEY: begin
              event_code  <= q_data.key[sel];
              event_value <= 1'b0;
              if (q_data.modk[sel] != '0) begin
                step <= STEP_MOD;
                rem  <= cur_rem;
              end else begin
                step <= STEP_BUTTON;
                rem  <= cur_rem & ~sel_bit;
              end
            end
            STEP_MOD: begin
              event_code  <= q_data.modk[sel];
              event_value <= 1'b0;
              step        <= STEP_BUTTON;
              rem         <= cur_rem & ~sel_bit;
            end
            default: begin
              event_code  <= '0;
              event_value <= 1'b0;
              step        <= STEP_BUTTON;
              rem         <= '0;
            end
          endcase
        end
      end
    end
  end

  a_pop_needs_slot: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!out_valid || pop))
    else $error("report retired while output slot busy");

  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (step == STEP_BUTTON))
    else $error("sequencer idle in mid-button step");

  a_busy_has_work: assert property (@(posedge clk) disable iff (rst)
    busy |-> q_valid)
    else $error("sequencer busy with no report queued");

endmodule

// File: rtl/key_combo_to_mouse_button_mapper.sv
// Key combination to mouse button mapper.
//
// Input channel (push/full): key events (op key) and sync reports (op sync).
// A request is taken on any edge with push high and full low. Key events
// update the held state of configured keys and modifiers; they never make
// results. A sync report with a pending change may produce a run of up to
// ten results: per changed button a mouse button event, and on a press the
// synthetic releases of its key and modifier, then a closing sync copy
// flagged by last_event.
// Output channel (empty/pop): the oldest result sits on the event ports
// while empty is low and retires on an edge with pop high.
// The first result of a run passes through the report queue and the
// registered output. The front end takes one request per cycle while full
// is low; the back end retires one result per cycle while the receiver pops.
// A two-entry report queue decouples them: full is high while two reports
// are queued, the one being sequenced included.
// Reset (rst, synchronous) restores default registers, releases all keys,
// drops pending reports and empties queue and output.
// Configuration: write_enable/write_index/write_data, one cycle, when idle.
module key_combo_to_mouse_button_mapper
  import kcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           op,
  input  logic [IN_CODE_W-1:0] key_code,
  input  logic [1:0]           key_value,
  output logic                 empty,
  input  logic                 pop,
  output logic                 event_kind,
  output logic [CODE_W-1:0]    event_code,
  output logic                 event_value,
  output logic                 last_event,
  input  logic                 write_enable,
  input  logic [REG_IDX_W-1:0] write_index,
  input  logic [CODE_W-1:0]    write_data
);

  // front end -> queue
  logic    q_push;
  report_t q_wdata;
  // queue -> back end
  logic    q_valid;
  logic    q_pop;
  report_t q_rdata;

  // classification, key state and button evaluation
  kcm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .key_code     (key_code),
    .key_value    (key_value),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  // short queue of report requests
  kcm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // result sequencer with registered output
  kcm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .event_kind  (event_kind),
    .event_code  (event_code),
    .event_value (event_value),
    .last_event  (last_event)
  );

endmodule

// File: test/key_combo_to_mouse_button_mapper_test.sv
`timescale 1ns / 100ps

// Checks the key combination to mouse button mapper end to end. Requests go
// in through the push/full side and button events come out through the
// empty/pop side. A predictor in this module tracks held keys, button state
// and the pending mark, and queues the events that each accepted request
// should produce. Every popped event is checked against the head of that
// queue.
module key_combo_to_mouse_button_mapper_test;
  import kcm_pkg::*;

  // op codes the package leaves unnamed; both are dropped by the block
  localparam logic [1:0] OP_OTHER_SYNC = 2'd2;
  localparam logic [1:0] OP_SPARE      = 2'd3;

  // key values
  localparam logic [1:0] KEY_UP     = 2'd0;
  localparam logic [1:0] KEY_DOWN   = 2'd1;
  localparam logic [1:0] KEY_REPEAT = 2'd2;

  // longest run: every button pressed with a modifier, plus the sync copy
  localparam int MAX_RUN       = BUTTONS * 3 + 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_ITEMS   = 42;
  localparam int CYCLE_LIMIT   = 400000;

  // one result of the block, fields in port order
  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] code;
    logic              value;
    logic              last;
  } mouse_event_t;

  // one directed request; typed >= 0 takes that many hand-written events,
  // typed < 0 leaves the expected events to the predictor
  typedef struct packed {
    logic [1:0]           op;
    logic [IN_CODE_W-1:0] code;
    logic [1:0]           value;
    int                   typed;
  } directed_request_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [1:0]           op = OP_KEY;
  logic [IN_CODE_W-1:0] key_code = '0;
  logic [1:0]           key_value = KEY_UP;
  logic                 empty;
  logic                 pop = 1'b0;
  logic                 event_kind;
  logic [CODE_W-1:0]    event_code;
  logic                 event_value;
  logic                 last_event;
  logic                 write_enable = 1'b0;
  logic [REG_IDX_W-1:0] write_index = REG_BUTTON_COUNT;
  logic [CODE_W-1:0]    write_data = '0;

  key_combo_to_mouse_button_mapper DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .key_code     (key_code),
    .key_value    (key_value),
    .empty        (empty),
    .pop          (pop),
    .event_kind   (event_kind),
    .event_code   (event_code),
    .event_value  (event_value),
    .last_event   (last_event),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor state: register copies, held slots, button state, pending.
  // Slot 2b is the key of button b, slot 2b+1 its modifier.
  // ---------------------------------------------------------------------
  logic [1:0]         layout_count;
  logic [CODE_W-1:0]  layout_key [BUTTONS];
  logic [CODE_W-1:0]  layout_mod [BUTTONS];
  bit                 slot_held [SLOTS];
  logic [BUTTONS-1:0] buttons_down;
  bit                 change_waiting;

  mouse_event_t queued_mouse_events [$];   // waiting for the output side
  mouse_event_t run_events [$];            // produced by the latest request

  int  error_count = 0;
  int  cycle_count = 0;
  bit  sender_idles = 1'b1;
  bit  receiver_idles = 1'b1;
  bit  long_hold_wanted = 1'b0;
  int  typed_cursor = 0;

  // Default layout: plain button one on key 125, buttons two and three on
  // the same key behind modifiers 56 and 100, so they override button one.
  directed_request_t directed_requests [0:24] = '{
    '{OP_SYNC,       16'd0,                      KEY_UP,      0}, // nothing pending
    '{OP_KEY,        16'(RST_FIRST_KEY),         KEY_DOWN,    0},
    '{OP_SYNC,       16'd0,                      KEY_UP,      3}, // plain left press
    '{OP_KEY,        16'(RST_SECOND_MODIFIER),   KEY_REPEAT,  0}, // repeat = pressed
    '{OP_SYNC,       16'd0,                      KEY_UP,      5}, // middle overrides left
    '{OP_KEY,        16'(RST_SECOND_MODIFIER),   KEY_UP,      0},
    '{OP_SYNC,       16'd0,                      KEY_UP,      2}, // held before: still overrides
    '{OP_SYNC,       16'd0,                      KEY_UP,      0}, // pending cleared
    '{OP_KEY,        16'(RST_FIRST_KEY),         KEY_UP,      0},
    '{OP_SYNC,       16'd0,                      KEY_UP,      0}, // change without effect
    '{OP_KEY,        16'd0,                      KEY_DOWN,    0}, // code zero
    '{OP_KEY,        16'(KEY_CODE_LIMIT),        KEY_DOWN,    0}, // at the limit
    '{OP_KEY,        16'hFFFF,                   KEY_REPEAT,  0}, // all ones
    '{OP_OTHER_SYNC, 16'(RST_FIRST_KEY),         KEY_DOWN,    0},
    '{OP_SPARE,      16'(RST_FIRST_KEY),         KEY_DOWN,    0},
    '{OP_SYNC,       16'd0,                      KEY_UP,      0}, // ignored ones left no mark
    '{OP_KEY,        16'(RST_THIRD_MODIFIER),    KEY_DOWN,    0},
    '{OP_KEY,        16'(RST_FIRST_KEY),         KEY_REPEAT,  0},
    '{OP_KEY,        16'(RST_SECOND_MODIFIER),   KEY_DOWN,    0},
    '{OP_SYNC,       16'd0,                      KEY_UP,      7}, // two combos at once
    '{OP_KEY,        16'(RST_THIRD_MODIFIER),    KEY_UP,     -1},
    '{OP_SYNC,       16'd0,                      KEY_UP,     -1},
    '{OP_KEY,        16'(RST_FIRST_KEY),         KEY_UP,     -1},
    '{OP_SYNC,       16'd0,                      KEY_UP,     -1},
    '{OP_KEY,        16'd767,                    KEY_DOWN,   -1}  // unmapped top code
  };

  mouse_event_t typed_events [0:16] = '{
    '{KIND_KEY,  MOUSE_LEFT_CODE,     1'b1, 1'b0},
    '{KIND_KEY,  RST_FIRST_KEY,       1'b0, 1'b0},
    '{KIND_SYNC, 10'd0,               1'b0, 1'b1},
    '{KIND_KEY,  MOUSE_LEFT_CODE,     1'b0, 1'b0},
    '{KIND_KEY,  MOUSE_MIDDLE_CODE,   1'b1, 1'b0},
    '{KIND_KEY,  RST_SECOND_KEY,      1'b0, 1'b0},
    '{KIND_KEY,  RST_SECOND_MODIFIER, 1'b0, 1'b0},
    '{KIND_SYNC, 10'd0,               1'b0, 1'b1},
    '{KIND_KEY,  MOUSE_MIDDLE_CODE,   1'b0, 1'b0},
    '{KIND_SYNC, 10'd0,               1'b0, 1'b1},
    '{KIND_KEY,  MOUSE_MIDDLE_CODE,   1'b1, 1'b0},
    '{KIND_KEY,  RST_SECOND_KEY,      1'b0, 1'b0},
    '{KIND_KEY,  RST_SECOND_MODIFIER, 1'b0, 1'b0},
    '{KIND_KEY,  MOUSE_RIGHT_CODE,    1'b1, 1'b0},
    '{KIND_KEY,  RST_THIRD_KEY,       1'b0, 1'b0},
    '{KIND_KEY,  RST_THIRD_MODIFIER,  1'b0, 1'b0},
    '{KIND_SYNC, 10'd0,               1'b0, 1'b1}
  };

  function automatic void reset_layout();
    layout_count  = RST_BUTTON_COUNT;
    layout_key[0] = RST_FIRST_KEY;
    layout_mod[0] = RST_FIRST_MODIFIER;
    layout_key[1] = RST_SECOND_KEY;
    layout_mod[1] = RST_SECOND_MODIFIER;
    layout_key[2] = RST_THIRD_KEY;
    layout_mod[2] = RST_THIRD_MODIFIER;
    foreach (slot_held[s]) slot_held[s] = 1'b0;
    buttons_down   = '0;
    change_waiting = 1'b0;
  endfunction

  // count zero acts as one, anything above BUTTONS saturates
  function automatic int buttons_in_use();
    int n;
    n = int'(layout_count);
    if (n == 0) n = 1;
    if (n > BUTTONS) n = BUTTONS;
    return n;
  endfunction

  function automatic logic [CODE_W-1:0] key_for(int b);
    if (b >= buttons_in_use()) return '0;
    return layout_key[b];
  endfunction

  // a button without a key has no modifier either
  function automatic logic [CODE_W-1:0] mod_for(int b);
    if (key_for(b) == '0) return '0;
    return layout_mod[b];
  endfunction

  // two-button layouts put button two on the right; anything past the
  // count keeps its three-button code
  function automatic logic [CODE_W-1:0] mouse_for(int b);
    if (b == 0) return MOUSE_LEFT_CODE;
    if (buttons_in_use() == 2 && b == 1) return MOUSE_RIGHT_CODE;
    if (b == 1) return MOUSE_MIDDLE_CODE;
    return MOUSE_RIGHT_CODE;
  endfunction

  // a key or modifier write releases that slot; button state is kept
  function automatic void apply_register(logic [REG_IDX_W-1:0] idx,
                                         logic [CODE_W-1:0] data);
    case (idx)
      REG_BUTTON_COUNT: begin
        layout_count = data[1:0];
      end
      REG_FIRST_KEY: begin
        layout_key[0] = data;
        slot_held[0] = 1'b0;
      end
      REG_FIRST_MODIFIER: begin
        layout_mod[0] = data;
        slot_held[1] = 1'b0;
      end
      REG_SECOND_KEY: begin
        layout_key[1] = data;
        slot_held[2] = 1'b0;
      end
      REG_SECOND_MODIFIER: begin
        layout_mod[1] = data;
        slot_held[3] = 1'b0;
      end
      REG_THIRD_KEY: begin
        layout_key[2] = data;
        slot_held[4] = 1'b0;
      end
      REG_THIRD_MODIFIER: begin
        layout_mod[2] = data;
        slot_held[5] = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  // Advances the predicted state by one request and leaves the events it
  // should produce in run_events.
  function automatic void map_key_request(logic [1:0] req_op,
                                          logic [IN_CODE_W-1:0] req_code,
                                          logic [1:0] req_value);
    logic [BUTTONS-1:0] down;
    logic [BUTTONS-1:0] cancel;
    bit                 held;
    run_events.delete();
    down   = '0;
    cancel = '0;
    held   = (req_value != KEY_UP);
    if (req_op == OP_KEY) begin
      if (req_code == '0 || req_code >= IN_CODE_W'(KEY_CODE_LIMIT)) return;
      for (int b = 0; b < BUTTONS; b++) begin
        if (IN_CODE_W'(key_for(b)) == req_code) begin
          slot_held[2*b] = held;
          change_waiting = 1'b1;
        end
        if (mod_for(b) != '0 && IN_CODE_W'(mod_for(b)) == req_code) begin
          slot_held[2*b+1] = held;
          change_waiting = 1'b1;
        end
      end
      return;
    end
    if (req_op != OP_SYNC || !change_waiting) return;
    change_waiting = 1'b0;

    for (int b = 0; b < BUTTONS; b++) begin
      if (key_for(b) == '0) continue;
      if (slot_held[2*b] && (mod_for(b) == '0 || slot_held[2*b+1])) down[b] = 1'b1;
    end
    // a modifier combo, pressed now or before, hides the lowest plain
    // button sharing its key
    for (int j = 0; j < BUTTONS; j++) begin
      if (mod_for(j) == '0) continue;
      if (!(down[j] || buttons_down[j])) continue;
      for (int b = 0; b < BUTTONS; b++) begin
        if (key_for(b) != '0 && mod_for(b) == '0 && key_for(b) == key_for(j)) begin
          cancel[b] = 1'b1;
          break;
        end
      end
    end
    down &= ~cancel;

    for (int b = 0; b < BUTTONS; b++) begin
      if (down[b] == buttons_down[b]) continue;
      buttons_down[b] = down[b];
      run_events.push_back('{KIND_KEY, mouse_for(b), down[b], 1'b0});
      if (down[b]) begin
        run_events.push_back('{KIND_KEY, key_for(b), 1'b0, 1'b0});
        if (mod_for(b) != '0) run_events.push_back('{KIND_KEY, mod_for(b), 1'b0, 1'b0});
      end
    end
    if (run_events.size() == 0 || run_events.size() >= MAX_RUN) return;
    run_events.push_back('{KIND_SYNC, '0, 1'b0, 1'b1});
  endfunction

  task automatic report_mismatch(string field, int got_v, int want_v);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got_v, want_v);
    error_count++;
  endtask

  // ---------------------------------------------------------------------
  // Sender. A request stays on the ports until an edge sees push high and
  // full low; the predictor runs at that same edge. With idling on, push
  // drops ahead of each request unless the randomly drawn gap is zero.
  // ---------------------------------------------------------------------
  task automatic send_request(logic [1:0] req_op, logic [IN_CODE_W-1:0] req_code,
                              logic [1:0] req_value, int typed = -1);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    op        <= req_op;
    key_code  <= req_code;
    key_value <= req_value;
    do @(posedge clk); while (full !== 1'b0);
    map_key_request(req_op, req_code, req_value);
    if (typed < 0) begin
      foreach (run_events[i]) queued_mouse_events.push_back(run_events[i]);
    end else begin
      repeat (typed) queued_mouse_events.push_back(typed_events[typed_cursor++]);
    end
  endtask

  // Mostly key events on codes of the current layout, so that combos
  // actually form; a quarter are reports; the rest is noise.
  task automatic send_random_request();
    int unsigned pick;
    int unsigned slot;
    logic [CODE_W-1:0] code;
    pick = $urandom_range(0, 99);
    slot = $urandom_range(0, SLOTS - 1);
    code = slot[0] ? layout_mod[slot/2] : layout_key[slot/2];
    if (pick < 25)
      send_request(OP_SYNC, IN_CODE_W'($urandom_range(0, 65535)), 2'($urandom_range(0, 2)));
    else if (pick < 85)
      send_request(OP_KEY, IN_CODE_W'(code), 2'($urandom_range(0, 2)));
    else if (pick < 93)
      send_request(OP_KEY, IN_CODE_W'($urandom_range(0, 65535)), 2'($urandom_range(0, 2)));
    else
      send_request(pick[0] ? OP_SPARE : OP_OTHER_SYNC,
                   IN_CODE_W'($urandom_range(0, 65535)), 2'($urandom_range(0, 2)));
  endtask

  // Registers are only touched once all expected events are out and the
  // block has had the settle wait to finish any report without results.
  task automatic settle_idle();
    push <= 1'b0;
    while (queued_mouse_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [CODE_W-1:0] data);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= data;
    @(posedge clk);
    apply_register(idx, data);
  endtask

  task automatic program_layout(logic [1:0] count,
                                logic [CODE_W-1:0] k0, logic [CODE_W-1:0] m0,
                                logic [CODE_W-1:0] k1, logic [CODE_W-1:0] m1,
                                logic [CODE_W-1:0] k2, logic [CODE_W-1:0] m2);
    write_register(REG_BUTTON_COUNT, CODE_W'(count));
    write_register(REG_FIRST_KEY, k0);
    write_register(REG_FIRST_MODIFIER, m0);
    write_register(REG_SECOND_KEY, k1);
    write_register(REG_SECOND_MODIFIER, m1);
    write_register(REG_THIRD_KEY, k2);
    write_register(REG_THIRD_MODIFIER, m2);
    write_enable <= 1'b0;
  endtask

  // shared key most of the time so overrides come up often
  function automatic logic [CODE_W-1:0] pick_layout_key(logic [CODE_W-1:0] shared);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return shared;
    if (r < 9) return CODE_W'($urandom_range(1, KEY_CODE_LIMIT - 1));
    return '0;
  endfunction

  function automatic logic [CODE_W-1:0] pick_layout_mod();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return '0;
    return CODE_W'($urandom_range(1, KEY_CODE_LIMIT - 1));
  endfunction

  // ---------------------------------------------------------------------
  // Receiver. Pops with random stalls; on request it holds off for a long
  // stretch so the block fills and pushes back on the sender.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned  stall;
    mouse_event_t got;
    mouse_event_t want;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (long_hold_wanted) begin
        long_hold_wanted = 1'b0;
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = receiver_idles ? $urandom_range(0, 19) : 0;
        if (stall > 0) begin
          pop <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      got = '{event_kind, event_code, event_value, last_event};
      if (queued_mouse_events.size() == 0) begin
        report_mismatch("unexpected event code", int'(got.code), -1);
      end else begin
        want = queued_mouse_events.pop_front();
        if (got.kind !== want.kind)
          report_mismatch("event_kind", int'(got.kind), int'(want.kind));
        if (got.code !== want.code)
          report_mismatch("event_code", int'(got.code), int'(want.code));
        if (got.value !== want.value)
          report_mismatch("event_value", int'(got.value), int'(want.value));
        if (got.last !== want.last)
          report_mismatch("last_event", int'(got.last), int'(want.last));
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("key_combo_to_mouse_button_mapper verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence: directed requests on the reset layout, then phases over
  // fixed and random layouts, then a back-pressure phase.
  // ---------------------------------------------------------------------
  initial begin
    logic [CODE_W-1:0] shared;
    reset_layout();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_requests[i])
      send_request(directed_requests[i].op, directed_requests[i].code,
                   directed_requests[i].value, directed_requests[i].typed);

    for (int phase = 0; phase < 9; phase++) begin
      settle_idle();
      sender_idles   = !(phase == 1 || phase == 6);
      receiver_idles = !(phase == 1 || phase == 6 || phase == 4);
      case (phase)
        0: program_layout(2'd3, 10'd1, 10'd767, 10'd767, 10'd1, 10'd1, 10'd0);
        1: program_layout(2'd3, 10'd10, 10'd20, 10'd30, 10'd40, 10'd50, 10'd60);
        2: program_layout(2'd1, 10'd125, 10'd0, 10'd125, 10'd56, 10'd125, 10'd100);
        3: program_layout(2'd2, 10'd200, 10'd0, 10'd200, 10'd300, 10'd5, 10'd6);
        4: program_layout(2'd0, 10'd7, 10'd8, 10'd9, 10'd0, 10'd7, 10'd0);
        default: begin
          shared = CODE_W'($urandom_range(1, KEY_CODE_LIMIT - 1));
          program_layout(2'($urandom_range(1, 3)),
                         pick_layout_key(shared), pick_layout_mod(),
                         pick_layout_key(shared), pick_layout_mod(),
                         pick_layout_key(shared), pick_layout_mod());
        end
      endcase
      if (phase == 1) begin
        // every combo pressed at once: the longest run, then all released
        for (int s = 0; s < SLOTS; s++)
          send_request(OP_KEY, IN_CODE_W'(10 * (s + 1)), KEY_DOWN);
        send_request(OP_SYNC, '0, KEY_UP);
        for (int s = 0; s < SLOTS; s++)
          send_request(OP_KEY, IN_CODE_W'(10 * (s + 1)), KEY_UP);
        send_request(OP_SYNC, '0, KEY_UP);
      end
      repeat (PHASE_ITEMS) send_random_request();
    end

    // back pressure: receiver parks while the sender keeps offering reports
    settle_idle();
    program_layout(RST_BUTTON_COUNT, RST_FIRST_KEY, RST_FIRST_MODIFIER,
                   RST_SECOND_KEY, RST_SECOND_MODIFIER, RST_THIRD_KEY,
                   RST_THIRD_MODIFIER);
    sender_idles     = 1'b0;
    receiver_idles   = 1'b1;
    long_hold_wanted = 1'b1;
    repeat (8) begin
      send_request(OP_KEY, IN_CODE_W'(RST_SECOND_KEY), KEY_DOWN);
      send_request(OP_KEY, IN_CODE_W'(RST_SECOND_MODIFIER), KEY_DOWN);
      send_request(OP_SYNC, '0, KEY_UP);
      send_request(OP_KEY, IN_CODE_W'(RST_SECOND_MODIFIER), KEY_UP);
      send_request(OP_KEY, IN_CODE_W'(RST_SECOND_KEY), KEY_UP);
      send_request(OP_SYNC, '0, KEY_UP);
    end
    push <= 1'b0;

    // drain, then give stray events a chance to show up
    while (queued_mouse_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && queued_mouse_events.size() == 0)
      $display("key_combo_to_mouse_button_mapper verification clean");
    else
      $display("key_combo_to_mouse_button_mapper verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/kcm_pkg.sv
rtl/kcm_front.sv
rtl/kcm_queue.sv
rtl/kcm_back.sv
rtl/key_combo_to_mouse_button_mapper.sv
test/key_combo_to_mouse_button_mapper_test.sv
